/* src/ffc_pkg.sv */
// ----------------------------------------------------------------------------
// ffc_pkg
// Shared types, constants and the CRC byte update for the frame checker.
// ----------------------------------------------------------------------------
package ffc_pkg;

  localparam logic [31:0] CRC_POLY         = 32'h04C1_1DB7;
  localparam logic [19:0] SECONDS_PER_WEEK = 20'd604800;
  localparam logic [11:0] TICKS_PER_SECOND = 12'd2000;
  localparam int          TIME_BYTES       = 6;

  // Frame verdict and captured time, handed from the frame stage to the decode stage
  typedef struct packed {
    logic        valid;
    logic        crc_match;
    logic [47:0] gps_time;
  } ffc_frame_res_t;

  // CRC-32, MSB first, one byte per call
  function automatic logic [31:0] crc_feed(input logic [31:0] crc_in, input logic [7:0] b);
    logic [31:0] c;
    c = crc_in ^ {b, 24'd0};
    for (int k = 0; k < 8; k++) begin
      if (c[31]) begin
        c = {c[30:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[30:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

/* src/ffc_frame.sv */
// ----------------------------------------------------------------------------
// ffc_frame
// Frame position, running CRC, trailer and time capture; registers one
// verdict per frame.
// ----------------------------------------------------------------------------
module ffc_frame #(
  parameter int FRAME_BYTES   = 2052,
  parameter int PAYLOAD_BYTES = 2048,
  parameter int TIME_OFFSET   = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_take,
  input  logic [7:0]             data_byte,
  input  logic                   frame_start,
  input  logic                   res_take,
  output ffc_pkg::ffc_frame_res_t res
);
  import ffc_pkg::*;

  localparam int POS_W = $clog2(FRAME_BYTES);
  localparam logic [POS_W-1:0] PAYLOAD_POS = POS_W'(PAYLOAD_BYTES);
  localparam logic [POS_W-1:0] TIME_FIRST  = POS_W'(TIME_OFFSET);
  localparam logic [POS_W-1:0] TIME_END    = POS_W'(TIME_OFFSET + TIME_BYTES);
  localparam logic [POS_W-1:0] LAST_POS    = POS_W'(FRAME_BYTES - 1);

  logic [POS_W-1:0] pos_r, pos_nxt, pos;
  logic [31:0]      crc_r, crc_nxt;
  logic [31:0]      trl_r, trl_nxt;
  logic [47:0]      time_r, time_nxt;
  logic             last;
  ffc_frame_res_t   res_r, res_nxt;

  assign pos  = frame_start ? '0 : pos_r;
  assign last = (pos >= LAST_POS);

  always_comb begin
    pos_nxt  = pos_r;
    crc_nxt  = crc_r;
    trl_nxt  = trl_r;
    time_nxt = time_r;
    if (in_take) begin
      if (pos < PAYLOAD_POS) begin
        crc_nxt = crc_feed((pos == '0) ? 32'd0 : crc_r, data_byte);
      end else begin
        trl_nxt = {trl_r[23:0], data_byte};
      end
      if (pos >= TIME_FIRST && pos < TIME_END) begin
        time_nxt = {time_r[39:0], data_byte};
      end
      pos_nxt = last ? '0 : pos + 1'b1;
    end
  end

  always_comb begin
    res_nxt = res_r;
    if (in_take) begin
      res_nxt.valid = last;
      if (last) begin
        res_nxt.crc_match = (crc_nxt == trl_nxt);
        res_nxt.gps_time  = time_nxt;
      end
    end else if (res_take) begin
      res_nxt.valid = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      crc_r       <= '0;
      trl_r       <= '0;
      time_r      <= '0;
      res_r.valid <= 1'b0;
    end else begin
      pos_r       <= pos_nxt;
      crc_r       <= crc_nxt;
      trl_r       <= trl_nxt;
      time_r      <= time_nxt;
      res_r.valid <= res_nxt.valid;
    end
    res_r.crc_match <= res_nxt.crc_match;
    res_r.gps_time  <= res_nxt.gps_time;
  end

  assign res = res_r;

endmodule

/* src/ffc_time.sv */
// ----------------------------------------------------------------------------
// ffc_time
// Splits the GPS time into week, seconds and ticks, forms total seconds and
// holds the result register.
// ----------------------------------------------------------------------------
module ffc_time (
  input  logic                    clk,
  input  logic                    rst_n,
  input  ffc_pkg::ffc_frame_res_t res,
  input  logic                    adv,
  output logic                    out_valid,
  output logic                    out_crc_match,
  output logic [15:0]             out_gps_week,
  output logic [19:0]             out_gps_second,
  output logic [11:0]             out_half_ms_ticks,
  output logic [35:0]             out_total_seconds
);
  import ffc_pkg::*;

  logic [15:0] week;
  logic [19:0] sec;
  logic [11:0] ticks;
  logic [1:0]  whole;
  logic [35:0] week_s;
  logic [35:0] total;

  logic        valid_r;
  logic        match_r;
  logic [15:0] week_r;
  logic [19:0] sec_r;
  logic [11:0] ticks_r;
  logic [35:0] total_r;

  assign week  = res.gps_time[47:32];
  assign sec   = res.gps_time[31:12];
  assign ticks = res.gps_time[11:0];

  // ticks < 4096, so at most two whole seconds
  always_comb begin
    priority if (ticks >= {TICKS_PER_SECOND[10:0], 1'b0}) begin
      whole = 2'd2;
    end else if (ticks >= TICKS_PER_SECOND) begin
      whole = 2'd1;
    end else begin
      whole = 2'd0;
    end
  end

  assign week_s = {20'd0, week} * {16'd0, SECONDS_PER_WEEK};
  assign total  = week_s + {16'd0, sec} + {34'd0, whole};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= res.valid;
    end
    if (adv && res.valid) begin
      match_r <= res.crc_match;
      week_r  <= week;
      sec_r   <= sec;
      ticks_r <= ticks;
      total_r <= total;
    end
  end

  assign out_valid         = valid_r;
  assign out_crc_match     = match_r;
  assign out_gps_week      = week_r;
  assign out_gps_second    = sec_r;
  assign out_half_ms_ticks = ticks_r;
  assign out_total_seconds = total_r;

endmodule

/* src/frame_crc_check_gps_time_top.sv */
// ----------------------------------------------------------------------------
// frame_crc_check_gps_time_top
// Frame CRC-32 check with GPS time capture on a byte stream.
// ----------------------------------------------------------------------------
// Takes one byte per transfer, one transfer per clock while in_stall is low.
// Bytes are cut into frames of FRAME_BYTES; CRC-32 (poly 04C11DB7, init 0,
// MSB first, no reflection, no final XOR) runs over the first PAYLOAD_BYTES
// and is compared with the big-endian trailer that follows. Six bytes at
// TIME_OFFSET form the 48-bit GPS time. One result transfer leaves for the
// last byte of each frame, registered first in ffc_frame and then in the
// result register of ffc_time, which holds while the output stalls.
// in_frame_start forces the byte to frame position zero and restarts the CRC;
// trailer and time keep old contents until new bytes arrive. No reset sweep.
// ----------------------------------------------------------------------------
module frame_crc_check_gps_time_top #(
  parameter int FRAME_BYTES   = 2052,
  parameter int PAYLOAD_BYTES = 2048,
  parameter int TIME_OFFSET   = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_frame_start,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_crc_match,
  output logic [15:0] out_gps_week,
  output logic [19:0] out_gps_second,
  output logic [11:0] out_half_ms_ticks,
  output logic [35:0] out_total_seconds
);
  import ffc_pkg::*;

  ffc_frame_res_t res;
  logic           adv;      // frame verdict moves into the result register
  logic           in_take;

  // Result register advances unless a held result is stalled.
  assign adv      = !(out_valid && out_stall);
  // Bytes keep flowing while the verdict slot is empty or draining.
  assign in_stall = res.valid && !adv;
  assign in_take  = in_valid && !in_stall;

  ffc_frame #(
    .FRAME_BYTES  (FRAME_BYTES),
    .PAYLOAD_BYTES(PAYLOAD_BYTES),
    .TIME_OFFSET  (TIME_OFFSET)
  ) u_frame (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_take    (in_take),
    .data_byte  (in_data_byte),
    .frame_start(in_frame_start),
    .res_take   (adv),
    .res        (res)
  );

  ffc_time u_time (
    .clk              (clk),
    .rst_n            (rst_n),
    .res              (res),
    .adv              (adv),
    .out_valid        (out_valid),
    .out_crc_match    (out_crc_match),
    .out_gps_week     (out_gps_week),
    .out_gps_second   (out_gps_second),
    .out_half_ms_ticks(out_half_ms_ticks),
    .out_total_seconds(out_total_seconds)
  );

endmodule

/* dv/frame_crc_check_gps_time_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frame_crc_check_gps_time_checker
// Watches both channels of the frame checker, predicts each frame verdict
// and compares it with what leaves the block.
// ----------------------------------------------------------------------------

package frame_check_tb_pkg;

  localparam logic [31:0] CRC32_POLY = 32'h04C1_1DB7;

  typedef struct packed {
    logic        crc_match;
    logic [15:0] gps_week;
    logic [19:0] gps_second;
    logic [11:0] half_ms_ticks;
    logic [35:0] total_seconds;
  } frame_verdict_t;

  // bitwise CRC-32 update, MSB of the byte first
  function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    logic        fb;
    c = crc;
    for (int i = 7; i >= 0; i--) begin
      fb = c[31] ^ b[i];
      c  = {c[30:0], 1'b0} ^ (fb ? CRC32_POLY : 32'd0);
    end
    return c;
  endfunction

endpackage

module frame_crc_check_gps_time_checker #(
  parameter int FRAME_BYTES   = 2052,
  parameter int PAYLOAD_BYTES = 2048,
  parameter int TIME_OFFSET   = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_frame_start,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic        out_crc_match,
  input  logic [15:0] out_gps_week,
  input  logic [19:0] out_gps_second,
  input  logic [11:0] out_half_ms_ticks,
  input  logic [35:0] out_total_seconds,
  output int          mismatch_count,
  output int          frames_outstanding
);
  import frame_check_tb_pkg::*;

  localparam int TIME_BYTES = 6;
  localparam int REPORT_MAX = 10;

  // predictor state
  logic [11:0] frame_pos;
  logic [31:0] payload_crc;
  logic [31:0] trailer_word;
  logic [47:0] gps_time;

  frame_verdict_t pending_verdicts[$];

  function automatic void take_byte(input logic [7:0] b, input logic start);
    logic [11:0]    p;
    frame_verdict_t v;
    p = start ? 12'd0 : frame_pos;
    if (p < PAYLOAD_BYTES) begin
      payload_crc = crc32_byte((p == 0) ? 32'd0 : payload_crc, b);
    end else begin
      trailer_word = {trailer_word[23:0], b};
    end
    if (p >= TIME_OFFSET && p < TIME_OFFSET + TIME_BYTES) begin
      gps_time = {gps_time[39:0], b};
    end
    if (p + 1 < FRAME_BYTES) begin
      frame_pos = p + 12'd1;
    end else begin
      frame_pos       = '0;
      v.crc_match     = (payload_crc == trailer_word);
      v.gps_week      = gps_time[47:32];
      v.gps_second    = gps_time[31:12];
      v.half_ms_ticks = gps_time[11:0];
      v.total_seconds = {20'd0, v.gps_week} * 36'd604800 + {16'd0, v.gps_second}
                        + {24'd0, v.half_ms_ticks} / 36'd2000;
      pending_verdicts.push_back(v);
    end
  endfunction

  function automatic void compare_verdict();
    frame_verdict_t want;
    if (pending_verdicts.size() == 0) begin
      if (mismatch_count < REPORT_MAX) begin
        $display("%0t: result transfer with no frame pending (crc=%0d week=%0d)",
                 $realtime, out_crc_match, out_gps_week);
      end
      mismatch_count++;
      return;
    end
    want = pending_verdicts.pop_front();
    if (out_crc_match !== want.crc_match || out_gps_week !== want.gps_week ||
        out_gps_second !== want.gps_second || out_half_ms_ticks !== want.half_ms_ticks ||
        out_total_seconds !== want.total_seconds) begin
      if (mismatch_count < REPORT_MAX) begin
        $display("%0t: exp crc=%0d wk=%0d s=%0d t=%0d tot=%0d",
                 $realtime, want.crc_match, want.gps_week, want.gps_second,
                 want.half_ms_ticks, want.total_seconds);
        $display("%0t: got crc=%0d wk=%0d s=%0d t=%0d tot=%0d",
                 $realtime, out_crc_match, out_gps_week,
                 out_gps_second, out_half_ms_ticks, out_total_seconds);
      end
      mismatch_count++;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      frame_pos    = '0;
      payload_crc  = '0;
      trailer_word = '0;
      gps_time     = '0;
      pending_verdicts.delete();
    end else begin
      if (in_valid && !in_stall) begin
        take_byte(in_data_byte, in_frame_start);
      end
      if (out_valid && !out_stall) begin
        compare_verdict();
      end
    end
    frames_outstanding <= pending_verdicts.size();
  end

endmodule

/* dv/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Byte stream stimulus for the frame CRC / GPS time checker: directed frames,
// a back-pressure phase and random well-formed, corrupted and broken frames.
// ----------------------------------------------------------------------------

module tb_top;

  import frame_check_tb_pkg::*;

  localparam int FRAME_BYTES    = 2052;
  localparam int PAYLOAD_BYTES  = 2048;
  localparam int TIME_OFFSET    = 16;
  localparam int CLK_PERIOD     = 20;
  localparam int RESET_CYCLES   = 7;
  localparam int IDLE_PERCENT   = 38;
  localparam int SETTLE_CYCLES  = 16;
  localparam int HOLD_CYCLES    = 3 * FRAME_BYTES; // long enough for results to back up
  localparam int RANDOM_FRAMES  = 40;            // closed frames wanted from the random part
  localparam int TIMEOUT_NS     = 20_000_000;    // several times the slow run

  // how the payload of a built frame is filled
  typedef enum logic [1:0] {
    FILL_RANDOM,
    FILL_ZERO,
    FILL_ONES
  } payload_fill_t;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_data_byte = '0;
  logic        in_frame_start = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_crc_match;
  logic [15:0] out_gps_week;
  logic [19:0] out_gps_second;
  logic [11:0] out_half_ms_ticks;
  logic [35:0] out_total_seconds;
  int          mismatch_count;
  int          frames_outstanding;

  // shared between stimulus and the receiver model
  logic        calm = 1'b0;     // no idling on either side while set
  logic        hold_req = 1'b0; // receiver to hold off for HOLD_CYCLES

  logic [7:0]  frame_buf [FRAME_BYTES];
  bit          at_boundary = 1'b1; // block expected to sit at frame position zero
  int          frames_closed = 0;

  frame_crc_check_gps_time_top #(
    .FRAME_BYTES   (FRAME_BYTES),
    .PAYLOAD_BYTES (PAYLOAD_BYTES),
    .TIME_OFFSET   (TIME_OFFSET)
  ) dut (.*);

  frame_crc_check_gps_time_checker #(
    .FRAME_BYTES   (FRAME_BYTES),
    .PAYLOAD_BYTES (PAYLOAD_BYTES),
    .TIME_OFFSET   (TIME_OFFSET)
  ) checker_i (.*);

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // backstop: a hung run or a frame that never reports ends here
  initial begin
    #(TIMEOUT_NS);
    $display("Mismatches found");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Receiver model. Random stall at roughly the idle rate, none while calm,
  // and one long counted hold-off on request so results back up into the
  // block and it has to stall its input.
  // --------------------------------------------------------------------------
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req  <= 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        out_stall <= !calm && ($urandom_range(99) < IDLE_PERCENT);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  // one byte transfer; random idle cycles ahead of it unless calm.
  // in_stall is read straight after the edge, so it is the value the edge saw.
  task automatic send_byte(input logic [7:0] b, input logic start);
    while (!calm && $urandom_range(99) < IDLE_PERCENT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_data_byte   <= b;
    in_frame_start <= start;
    do @(posedge clk); while (in_stall);
  endtask

  // payload, big-endian time at TIME_OFFSET, then the matching CRC trailer;
  // a corrupted frame gets one bit flipped anywhere after the CRC is taken
  task automatic make_frame(input payload_fill_t fill, input logic [47:0] gps,
                            input bit corrupt);
    logic [31:0] crc;
    int          idx;
    int          bitno;
    for (int k = 0; k < PAYLOAD_BYTES; k++) begin
      case (fill)
        FILL_ZERO: frame_buf[k] = 8'h00;
        FILL_ONES: frame_buf[k] = 8'hFF;
        default:   frame_buf[k] = 8'($urandom);
      endcase
    end
    for (int k = 0; k < 6; k++) frame_buf[TIME_OFFSET + k] = gps[47 - 8 * k -: 8];
    crc = '0;
    for (int k = 0; k < PAYLOAD_BYTES; k++) crc = crc32_byte(crc, frame_buf[k]);
    for (int k = 0; k < 4; k++) frame_buf[PAYLOAD_BYTES + k] = crc[31 - 8 * k -: 8];
    if (corrupt) begin
      idx   = $urandom_range(FRAME_BYTES - 1);
      bitno = $urandom_range(7);
      frame_buf[idx][bitno] = ~frame_buf[idx][bitno];
    end
  endtask

  // first count bytes of the built frame; only the first may carry a start
  task automatic send_frame(input int count, input logic start);
    for (int k = 0; k < count; k++) send_byte(frame_buf[k], (k == 0) ? start : 1'b0);
    at_boundary = (count == FRAME_BYTES);
    if (count == FRAME_BYTES) frames_closed++;
  endtask

  // sender stops until every predicted verdict has been seen, then settles
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (frames_outstanding != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // random time with a bias towards the extremes and the tick carry point
  function automatic logic [47:0] pick_gps_time();
    logic [47:0] t;
    t = {16'($urandom), 32'($urandom)};
    case ($urandom_range(7))
      0:       t = '1;
      1:       t = '0;
      2:       t[11:0] = 12'd1999;
      3:       t[11:0] = 12'd2000;
      4:       t[11:0] = 12'd4095;
      default: t = t;
    endcase
    return t;
  endfunction

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    int            pick;
    int            burst;
    payload_fill_t fill;

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // ---- directed frames ----
    // all zero: CRC of zeros is zero and so is the trailer, time all zero
    make_frame(FILL_ZERO, 48'h0, 1'b0);
    send_frame(FRAME_BYTES, 1'b1);
    // all ones, time at its maximum; runs straight on from the last frame
    make_frame(FILL_ONES, '1, 1'b0);
    send_frame(FRAME_BYTES, 1'b0);
    // ticks just below the carry into whole seconds, start on a natural boundary
    make_frame(FILL_RANDOM, {16'd0, 20'd0, 12'd1999}, 1'b0);
    send_frame(FRAME_BYTES, 1'b1);
    // ticks exactly one second
    make_frame(FILL_RANDOM, {16'd1, 20'd604799, 12'd2000}, 1'b0);
    send_frame(FRAME_BYTES, 1'b0);
    // broken CRC
    make_frame(FILL_RANDOM, pick_gps_time(), 1'b1);
    send_frame(FRAME_BYTES, 1'b0);
    // realigned half-way through the time bytes
    make_frame(FILL_RANDOM, 48'hA5A5_5A5A_F00F, 1'b0);
    send_frame(TIME_OFFSET + 3, 1'b0);
    make_frame(FILL_RANDOM, pick_gps_time(), 1'b0);
    send_frame(FRAME_BYTES, 1'b1);
    // realigned inside the trailer: stale trailer bytes get shifted out again
    make_frame(FILL_RANDOM, pick_gps_time(), 1'b0);
    send_frame(PAYLOAD_BYTES + 2, 1'b0);
    make_frame(FILL_RANDOM, pick_gps_time(), 1'b0);
    send_frame(FRAME_BYTES, 1'b1);
    // start on what would have been the last position: no verdict for it
    make_frame(FILL_RANDOM, pick_gps_time(), 1'b0);
    send_frame(FRAME_BYTES - 1, 1'b0);
    make_frame(FILL_RANDOM, pick_gps_time(), 1'b0);
    send_frame(FRAME_BYTES, 1'b1);
    // start held over several consecutive bytes
    repeat (4) send_byte(8'($urandom), 1'b1);
    make_frame(FILL_RANDOM, pick_gps_time(), 1'b0);
    send_frame(FRAME_BYTES, 1'b1);
    wait_drained();

    // ---- back-pressure: receiver holds off, sender keeps offering ----
    calm     <= 1'b1;
    hold_req <= 1'b1;
    repeat (4) begin
      make_frame(FILL_RANDOM, pick_gps_time(), 1'b0);
      send_frame(FRAME_BYTES, !at_boundary);
    end
    calm <= 1'b0;
    wait_drained();

    // ---- random frames ----
    // mostly well-formed frames with random content; some corrupted, some
    // cut short by a realignment, some bursts of loose bytes and starts
    frames_closed = 0;
    while (frames_closed < RANDOM_FRAMES) begin
      if (frames_closed == 8)  calm <= 1'b1;
      if (frames_closed == 12) calm <= 1'b0;
      if (frames_closed == 20 && at_boundary) wait_drained();
      pick = $urandom_range(99);
      case ($urandom_range(19))
        0:       fill = FILL_ZERO;
        1:       fill = FILL_ONES;
        default: fill = FILL_RANDOM;
      endcase
      if (pick < 65) begin
        make_frame(fill, pick_gps_time(), 1'b0);
        send_frame(FRAME_BYTES, !at_boundary || ($urandom_range(1) == 1));
      end else if (pick < 78) begin
        make_frame(fill, pick_gps_time(), 1'b1);
        send_frame(FRAME_BYTES, !at_boundary || ($urandom_range(1) == 1));
      end else if (pick < 90) begin
        make_frame(fill, pick_gps_time(), 1'b0);
        send_frame($urandom_range(1, FRAME_BYTES - 1), !at_boundary);
      end else begin
        burst = $urandom_range(1, 40);
        repeat (burst) send_byte(8'($urandom), $urandom_range(3) == 0);
        at_boundary = 1'b0;
      end
    end

    // ---- end of run ----
    wait_drained();
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
